[rtl/multidim_index_offset_converter_macros.svh]
// assertion macros for the checker of the index converter
`ifndef MULTIDIM_INDEX_OFFSET_CONVERTER_MACROS_SVH
`define MULTIDIM_INDEX_OFFSET_CONVERTER_MACROS_SVH

// same-cycle implication, sampled on the rising clock edge outside reset
`define MIOC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on the rising clock edge outside reset
`define MIOC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/mioc_pkg.sv]
package mioc_pkg;

    // default sizes and fixed field widths
    localparam int MAX_DIMS_DEF   = 3;
    localparam int INDEX_BITS_DEF = 16;
    localparam int OFF_BITS       = 48;
    localparam int CFG_IDX_BITS   = 3;

    typedef enum logic [1:0] {
        OP_TO_INDEX  = 2'd0,
        OP_TO_OFFSET = 2'd1,
        OP_CONTAINS  = 2'd2,
        OP_OVERLAPS  = 2'd3
    } mioc_op_t;

    typedef enum logic [1:0] {
        ERR_OK     = 2'd0,
        ERR_OFFSET = 2'd1,
        ERR_RANGE  = 2'd2,
        ERR_BOUNDS = 2'd3
    } mioc_err_t;

    // register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_LOWER_0 = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_UPPER_0 = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_DIMS    = 3'd6;
    localparam logic [CFG_IDX_BITS-1:0] REG_ORDER   = 3'd7;

    // control carried along the cell chain
    typedef struct packed {
        logic      valid;
        mioc_op_t  op;
        mioc_err_t err;
        logic      test;
    } mioc_ctrl_t;

    // effective number of active dimensions
    function automatic logic [1:0] active_count(logic [1:0] dims, logic [1:0] md);
        logic [1:0] n;
        n = dims;
        if (n == 2'd0)
            n = 2'd1;
        if (n > md)
            n = md;
        return n;
    endfunction

    // dimension handled at a given fastest-first position (self inverse)
    function automatic logic [1:0] slot_dim(logic [1:0] k, logic [1:0] n, logic order);
        return order ? k : 2'(n - 2'd1 - k);
    endfunction

endpackage

[rtl/mioc_stream_if.sv]
// request channel
interface mioc_req_if #(
    parameter int INDEX_BITS = mioc_pkg::INDEX_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic [1:0]                    opcode;
    logic [mioc_pkg::OFF_BITS-1:0] linear_offset;
    logic signed [INDEX_BITS-1:0]  coord_0;
    logic signed [INDEX_BITS-1:0]  coord_1;
    logic signed [INDEX_BITS-1:0]  coord_2;
    logic signed [INDEX_BITS-1:0]  query_high_0;
    logic signed [INDEX_BITS-1:0]  query_high_1;
    logic signed [INDEX_BITS-1:0]  query_high_2;

    modport source (
        output valid, opcode, linear_offset, coord_0, coord_1, coord_2,
               query_high_0, query_high_1, query_high_2,
        input  ready
    );
    modport sink (
        input  valid, opcode, linear_offset, coord_0, coord_1, coord_2,
               query_high_0, query_high_1, query_high_2,
        output ready
    );
endinterface

// response channel
interface mioc_rsp_if #(
    parameter int INDEX_BITS = mioc_pkg::INDEX_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic [mioc_pkg::OFF_BITS-1:0] result_offset;
    logic signed [INDEX_BITS-1:0]  index_0;
    logic signed [INDEX_BITS-1:0]  index_1;
    logic signed [INDEX_BITS-1:0]  index_2;
    logic                          test_true;
    logic [1:0]                    error_code;

    modport source (
        output valid, result_offset, index_0, index_1, index_2, test_true, error_code,
        input  ready
    );
    modport sink (
        input  valid, result_offset, index_0, index_1, index_2, test_true, error_code,
        output ready
    );
endinterface

[rtl/mioc_front.sv]
module mioc_front #(
    parameter int MAX_DIMS   = mioc_pkg::MAX_DIMS_DEF,
    parameter int INDEX_BITS = mioc_pkg::INDEX_BITS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   en,
    mioc_req_if.sink                               req,
    input  logic signed [MAX_DIMS-1:0][INDEX_BITS-1:0] lower,
    input  logic signed [MAX_DIMS-1:0][INDEX_BITS-1:0] upper,
    input  logic [1:0]                             n,
    input  logic                                   order,
    output mioc_pkg::mioc_ctrl_t                   ctrl,
    output logic [mioc_pkg::OFF_BITS-1:0]          v,
    output logic [MAX_DIMS-1:0][INDEX_BITS-1:0]    d
);
    localparam int DB = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;

    logic signed [2:0][INDEX_BITS-1:0]       c_all;
    logic signed [2:0][INDEX_BITS-1:0]       q_all;
    mioc_pkg::mioc_ctrl_t                    ctrl_reg, ctrl_next;
    logic [mioc_pkg::OFF_BITS-1:0]           v_reg;
    logic [MAX_DIMS-1:0][INDEX_BITS-1:0]     d_reg, d_next;

    assign req.ready = en;
    assign c_all = {req.coord_2, req.coord_1, req.coord_0};
    assign q_all = {req.query_high_2, req.query_high_1, req.query_high_0};

    // bound checks, box tests and per-position index distances
    always_comb
    begin
        logic       bad_cfg, bad_rng, bad_q, cont, ovl;
        logic [1:0] di;
        bad_cfg = 1'b0;
        bad_rng = 1'b0;
        bad_q   = 1'b0;
        cont    = 1'b1;
        ovl     = 1'b1;
        for (int i = 0; i < MAX_DIMS; i++)
        begin
            if (2'(i) < n)
            begin
                if ($signed(upper[i]) < $signed(lower[i]))
                    bad_cfg = 1'b1;
                if ($signed(c_all[i]) < $signed(lower[i]) ||
                    $signed(c_all[i]) > $signed(upper[i]))
                    bad_rng = 1'b1;
                if ($signed(q_all[i]) < $signed(c_all[i]))
                    bad_q = 1'b1;
                if ($signed(c_all[i]) < $signed(lower[i]) ||
                    $signed(q_all[i]) > $signed(upper[i]))
                    cont = 1'b0;
                if ($signed(q_all[i]) < $signed(lower[i]) ||
                    $signed(c_all[i]) > $signed(upper[i]))
                    ovl = 1'b0;
            end
        end
        ctrl_next.valid = req.valid;
        ctrl_next.op    = mioc_pkg::mioc_op_t'(req.opcode);
        ctrl_next.err   = mioc_pkg::ERR_OK;
        ctrl_next.test  = 1'b0;
        if (bad_cfg)
            ctrl_next.err = mioc_pkg::ERR_BOUNDS;
        else
        begin
            case (ctrl_next.op)
                mioc_pkg::OP_TO_OFFSET:
                    if (bad_rng)
                        ctrl_next.err = mioc_pkg::ERR_RANGE;
                mioc_pkg::OP_CONTAINS:
                    if (bad_q)
                        ctrl_next.err = mioc_pkg::ERR_BOUNDS;
                    else
                        ctrl_next.test = cont;
                mioc_pkg::OP_OVERLAPS:
                    if (bad_q)
                        ctrl_next.err = mioc_pkg::ERR_BOUNDS;
                    else
                        ctrl_next.test = ovl;
                default: ;
            endcase
        end
        for (int k = 0; k < MAX_DIMS; k++)
        begin
            di = mioc_pkg::slot_dim(2'(k), n, order);
            if (2'(k) < n)
                d_next[k] = INDEX_BITS'(c_all[di[DB-1:0]] - lower[di[DB-1:0]]);
            else
                d_next[k] = '0;
        end
    end

    // transaction control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctrl_reg <= '0;
        else if (en)
            ctrl_reg <= ctrl_next;
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            v_reg <= req.linear_offset;
            d_reg <= d_next;
        end
    end

    assign ctrl = ctrl_reg;
    assign v    = v_reg;
    assign d    = d_reg;
endmodule

[rtl/mioc_cell.sv]
// one bit of mixed-radix division and up to one bit of offset folding
module mioc_cell #(
    parameter int MAX_DIMS   = mioc_pkg::MAX_DIMS_DEF,
    parameter int INDEX_BITS = mioc_pkg::INDEX_BITS_DEF,
    parameter int SLOT       = 0,
    parameter int STEP       = 0
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                en,
    input  logic [INDEX_BITS:0]                 e_div,
    input  logic [INDEX_BITS:0]                 e_mul,
    input  mioc_pkg::mioc_ctrl_t                ctrl_in,
    input  logic [mioc_pkg::OFF_BITS-1:0]       v_in,
    input  logic [INDEX_BITS:0]                 r_in,
    input  logic [mioc_pkg::OFF_BITS-1:0]       acc_in,
    input  logic [mioc_pkg::OFF_BITS-1:0]       acc2_in,
    input  logic [MAX_DIMS-1:0][INDEX_BITS-1:0] d_in,
    input  logic [MAX_DIMS-1:0][INDEX_BITS-1:0] rem_in,
    output mioc_pkg::mioc_ctrl_t                ctrl_out,
    output logic [mioc_pkg::OFF_BITS-1:0]       v_out,
    output logic [INDEX_BITS:0]                 r_out,
    output logic [mioc_pkg::OFF_BITS-1:0]       acc_out,
    output logic [mioc_pkg::OFF_BITS-1:0]       acc2_out,
    output logic [MAX_DIMS-1:0][INDEX_BITS-1:0] d_out,
    output logic [MAX_DIMS-1:0][INDEX_BITS-1:0] rem_out
);
    localparam int L    = mioc_pkg::OFF_BITS;
    localparam int EB   = INDEX_BITS + 1;
    localparam int MB   = (STEP < EB) ? EB - 1 - STEP : 0;
    localparam int MS   = MAX_DIMS - 1 - SLOT;
    localparam bit LAST = (STEP == L - 1);
    localparam bit MULT = (STEP < EB);

    logic [EB:0]                         t, diff;
    logic                                ge;
    mioc_pkg::mioc_ctrl_t                ctrl_reg;
    logic [L-1:0]                        v_reg, v_next, acc_reg, acc_next, acc2_reg, acc2_next;
    logic [EB-1:0]                       r_reg, r_next;
    logic [MAX_DIMS-1:0][INDEX_BITS-1:0] d_reg, rem_reg, rem_next;

    // restoring division step and shift-add multiply step
    always_comb
    begin
        t      = {r_in, v_in[L-1]};
        diff   = t - {1'b0, e_div};
        ge     = (t >= {1'b0, e_div});
        v_next = {v_in[L-2:0], ge};
        r_next = ge ? diff[EB-1:0] : t[EB-1:0];
        rem_next  = rem_in;
        acc_next  = acc_in;
        acc2_next = acc2_in;
        if (MULT && e_mul[MB])
            acc2_next = {acc2_in[L-2:0], 1'b0} + acc_in;
        else if (MULT)
            acc2_next = {acc2_in[L-2:0], 1'b0};
        // end of a position: keep the remainder, add the index distance
        if (LAST)
        begin
            rem_next[SLOT] = r_next[INDEX_BITS-1:0];
            r_next         = '0;
            acc_next       = acc2_in + L'(d_in[MS]);
            acc2_next      = '0;
        end
    end

    // transaction control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctrl_reg <= '0;
        else if (en)
            ctrl_reg <= ctrl_in;
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            v_reg         <= v_next;
            r_reg         <= r_next;
            acc_reg       <= acc_next;
            acc2_reg      <= acc2_next;
            d_reg         <= d_in;
            rem_reg       <= rem_next;
        end
    end

    assign ctrl_out = ctrl_reg;
    assign v_out    = v_reg;
    assign r_out    = r_reg;
    assign acc_out  = acc_reg;
    assign acc2_out = acc2_reg;
    assign d_out    = d_reg;
    assign rem_out  = rem_reg;
endmodule

[rtl/mioc_back.sv]
module mioc_back #(
    parameter int MAX_DIMS   = mioc_pkg::MAX_DIMS_DEF,
    parameter int INDEX_BITS = mioc_pkg::INDEX_BITS_DEF
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    output logic                                       en,
    input  mioc_pkg::mioc_ctrl_t                       ctrl,
    input  logic [mioc_pkg::OFF_BITS-1:0]              v,
    input  logic [mioc_pkg::OFF_BITS-1:0]              acc,
    input  logic [MAX_DIMS-1:0][INDEX_BITS-1:0]        rem,
    input  logic signed [MAX_DIMS-1:0][INDEX_BITS-1:0] lower,
    input  logic [1:0]                                 n,
    input  logic                                       order,
    mioc_rsp_if.source                                 rsp
);
    localparam int DB = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;

    logic                          valid_reg;
    logic [mioc_pkg::OFF_BITS-1:0] off_reg, off_next;
    logic [2:0][INDEX_BITS-1:0]    idx_reg, idx_next;
    logic                          test_reg, test_next;
    mioc_pkg::mioc_err_t           err_reg, err_next;

    assign en = !valid_reg || rsp.ready;

    // result assembly; an error clears every other field
    always_comb
    begin
        logic [1:0] k;
        off_next  = '0;
        idx_next  = '0;
        test_next = 1'b0;
        err_next  = ctrl.err;
        if (ctrl.err == mioc_pkg::ERR_OK)
        begin
            case (ctrl.op)
                mioc_pkg::OP_TO_INDEX:
                    if (v != '0)
                        err_next = mioc_pkg::ERR_OFFSET;
                    else
                        for (int i = 0; i < MAX_DIMS; i++)
                        begin
                            k = mioc_pkg::slot_dim(2'(i), n, order);
                            if (2'(i) < n)
                                idx_next[i] = lower[i] + rem[k[DB-1:0]];
                        end
                mioc_pkg::OP_TO_OFFSET:
                    off_next = acc;
                default:
                    test_next = ctrl.test;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= ctrl.valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            off_reg  <= off_next;
            idx_reg  <= idx_next;
            test_reg <= test_next;
            err_reg  <= err_next;
        end
    end

    assign rsp.valid         = valid_reg;
    assign rsp.result_offset = off_reg;
    assign rsp.index_0       = idx_reg[0];
    assign rsp.index_1       = idx_reg[1];
    assign rsp.index_2       = idx_reg[2];
    assign rsp.test_true     = test_reg;
    assign rsp.error_code    = err_reg;
endmodule

[rtl/multidim_index_offset_converter.sv]
// Index box converter: one transaction per cycle while not stalled, for every
// opcode. A chain of bit cells runs the mixed-radix division of the 48-bit
// offset, one quotient bit per cell and 48 cells per dimension; the same cells
// fold indices into an offset by shift-and-add. The whole chain advances while
// the output register is empty or being taken. Configuration must be written
// only while no transaction is in flight.
module multidim_index_offset_converter #(
    parameter int MAX_DIMS   = mioc_pkg::MAX_DIMS_DEF,
    parameter int INDEX_BITS = mioc_pkg::INDEX_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    mioc_req_if.sink                          req,
    mioc_rsp_if.source                        rsp,
    input  logic                              cfg_we,
    input  logic [mioc_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  logic [INDEX_BITS-1:0]             cfg_data
);
    localparam int L  = mioc_pkg::OFF_BITS;
    localparam int EB = INDEX_BITS + 1;
    localparam int NC = MAX_DIMS * L;
    localparam int DB = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;

    logic signed [MAX_DIMS-1:0][INDEX_BITS-1:0] lower_reg, upper_reg;
    logic [1:0]                                 dims_reg;
    logic                                       order_reg;
    logic [1:0]                                 n;
    logic [MAX_DIMS-1:0][EB-1:0]                ext_dim, ext_slot;
    logic                                       en;

    mioc_pkg::mioc_ctrl_t                ctrl_s [NC+1];
    logic [L-1:0]                        v_s    [NC+1];
    logic [EB-1:0]                       r_s    [NC+1];
    logic [L-1:0]                        acc_s  [NC+1];
    logic [L-1:0]                        acc2_s [NC+1];
    logic [MAX_DIMS-1:0][INDEX_BITS-1:0] d_s    [NC+1];
    logic [MAX_DIMS-1:0][INDEX_BITS-1:0] rem_s  [NC+1];

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lower_reg <= '0;
            upper_reg <= '0;
            dims_reg  <= 2'd1;
            order_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            for (int i = 0; i < MAX_DIMS; i++)
            begin
                if (cfg_index == mioc_pkg::CFG_IDX_BITS'(mioc_pkg::REG_LOWER_0 + i))
                    lower_reg[i] <= cfg_data;
                if (cfg_index == mioc_pkg::CFG_IDX_BITS'(mioc_pkg::REG_UPPER_0 + i))
                    upper_reg[i] <= cfg_data;
            end
            case (cfg_index)
                mioc_pkg::REG_DIMS:  dims_reg  <= cfg_data[1:0];
                mioc_pkg::REG_ORDER: order_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // extents per dimension and per fastest-first position
    always_comb
    begin
        logic [1:0] di;
        n = mioc_pkg::active_count(dims_reg, 2'(MAX_DIMS));
        for (int i = 0; i < MAX_DIMS; i++)
            ext_dim[i] = {upper_reg[i][INDEX_BITS-1], upper_reg[i]}
                       - {lower_reg[i][INDEX_BITS-1], lower_reg[i]} + EB'(1);
        for (int k = 0; k < MAX_DIMS; k++)
        begin
            di = mioc_pkg::slot_dim(2'(k), n, order_reg);
            ext_slot[k] = (2'(k) < n) ? ext_dim[di[DB-1:0]] : EB'(1);
        end
    end

    mioc_front #(.MAX_DIMS(MAX_DIMS), .INDEX_BITS(INDEX_BITS)) u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .req   (req),
        .lower (lower_reg),
        .upper (upper_reg),
        .n     (n),
        .order (order_reg),
        .ctrl  (ctrl_s[0]),
        .v     (v_s[0]),
        .d     (d_s[0])
    );

    assign r_s[0]    = '0;
    assign acc_s[0]  = '0;
    assign acc2_s[0] = '0;
    assign rem_s[0]  = '0;

    // chain of bit cells, 48 per dimension position
    for (genvar g = 0; g < NC; g++)
    begin : g_cell
        mioc_cell #(
            .MAX_DIMS   (MAX_DIMS),
            .INDEX_BITS (INDEX_BITS),
            .SLOT       (g / L),
            .STEP       (g % L)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .e_div    (ext_slot[g / L]),
            .e_mul    (ext_slot[MAX_DIMS - 1 - g / L]),
            .ctrl_in  (ctrl_s[g]),
            .v_in     (v_s[g]),
            .r_in     (r_s[g]),
            .acc_in   (acc_s[g]),
            .acc2_in  (acc2_s[g]),
            .d_in     (d_s[g]),
            .rem_in   (rem_s[g]),
            .ctrl_out (ctrl_s[g+1]),
            .v_out    (v_s[g+1]),
            .r_out    (r_s[g+1]),
            .acc_out  (acc_s[g+1]),
            .acc2_out (acc2_s[g+1]),
            .d_out    (d_s[g+1]),
            .rem_out  (rem_s[g+1])
        );
    end

    mioc_back #(.MAX_DIMS(MAX_DIMS), .INDEX_BITS(INDEX_BITS)) u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .ctrl  (ctrl_s[NC]),
        .v     (v_s[NC]),
        .acc   (acc_s[NC]),
        .rem   (rem_s[NC]),
        .lower (lower_reg),
        .n     (n),
        .order (order_reg),
        .rsp   (rsp)
    );
endmodule

[rtl/mioc_checker.sv]
`include "multidim_index_offset_converter_macros.svh"

module mioc_checker #(
    parameter int INDEX_BITS = mioc_pkg::INDEX_BITS_DEF
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          req_ready,
    input logic                          rsp_valid,
    input logic                          rsp_ready,
    input logic [mioc_pkg::OFF_BITS-1:0] result_offset,
    input logic [INDEX_BITS-1:0]         index_0,
    input logic [INDEX_BITS-1:0]         index_1,
    input logic [INDEX_BITS-1:0]         index_2,
    input logic                          test_true,
    input logic [1:0]                    error_code
);
    // a stalled result holds its valid, offset, error code and first index
    `MIOC_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(result_offset) && $stable(error_code) && $stable(index_0), "stalled result changed")

    // the chain advances exactly when the output register can move
    `MIOC_ASSERT_NOW(a_ready_follows, 1'b1, req_ready == (!rsp_valid || rsp_ready), "ready does not follow output stall")

    // an error clears every other field
    `MIOC_ASSERT_NOW(a_err_clean, rsp_valid && error_code != mioc_pkg::ERR_OK, result_offset == '0 && index_0 == '0 && index_1 == '0 && index_2 == '0 && !test_true, "error result carries data")

    // an offset answer carries neither indices nor a test answer
    `MIOC_ASSERT_NOW(a_off_only, rsp_valid && result_offset != '0, !test_true && index_0 == '0 && index_1 == '0 && index_2 == '0, "offset result mixed with other fields")
endmodule

bind multidim_index_offset_converter mioc_checker #(.INDEX_BITS(INDEX_BITS)) u_mioc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_ready     (req.ready),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .result_offset (rsp.result_offset),
    .index_0       (rsp.index_0),
    .index_1       (rsp.index_1),
    .index_2       (rsp.index_2),
    .test_true     (rsp.test_true),
    .error_code    (rsp.error_code)
);
